// ----- rtl/core/gta_pkg.sv -----
// Shared types and tower-field arithmetic functions for the GF(256) tower ALU.
package gta_pkg;

  typedef enum logic {
    CMD_ADD = 1'b0,
    CMD_MUL = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    FIELD_GF2   = 2'd0,
    FIELD_GF4   = 2'd1,
    FIELD_GF16  = 2'd2,
    FIELD_GF256 = 2'd3
  } field_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] mask;
    logic [7:0] a;
    logic [7:0] b;
  } prep_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] mask;
    logic [7:0] sum;
    logic [3:0] lo;
    logic [3:0] hi;
    logic [3:0] mid;
  } part_t;

  function automatic logic [7:0] field_mask(input logic [1:0] sel);
    logic [7:0] m;
    unique case (sel)
      FIELD_GF2:   m = 8'h01;
      FIELD_GF4:   m = 8'h03;
      FIELD_GF16:  m = 8'h0f;
      default:     m = 8'hff;
    endcase
    return m;
  endfunction

  function automatic logic [1:0] gf4_by_x(input logic [1:0] a);
    return {a[0] ^ a[1], a[1]};
  endfunction

  function automatic logic [1:0] gf4_by_x1(input logic [1:0] a);
    return {a[0], a[0] ^ a[1]};
  endfunction

  function automatic logic [1:0] gf4_mul(input logic [1:0] a, input logic [1:0] b);
    return (b[0] ? a : 2'b00) ^ (b[1] ? gf4_by_x(a) : 2'b00);
  endfunction

  function automatic logic [3:0] gf16_karatsuba(input logic [3:0] a, input logic [3:0] b);
    logic [1:0] lo;
    logic [1:0] hi;
    logic [1:0] mid;
    lo  = gf4_mul(a[1:0], b[1:0]);
    hi  = gf4_mul(a[3:2], b[3:2]);
    mid = gf4_mul(a[1:0] ^ a[3:2], b[1:0] ^ b[3:2]) ^ lo ^ hi;
    return {mid ^ hi, lo ^ gf4_by_x(hi)};
  endfunction

  function automatic logic [3:0] gf16_by_8(input logic [3:0] a);
    return {gf4_by_x(a[1:0] ^ a[3:2]), gf4_by_x1(a[3:2])};
  endfunction

endpackage

// ----- rtl/core/gta_in_if.sv -----
// Operation channel: command, field select and two operands.
interface gta_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [1:0] field_select;
  logic [7:0] operand_a;
  logic [7:0] operand_b;

  modport source (output valid, output cmd, output field_select,
                  output operand_a, output operand_b, input ready);
  modport sink (input valid, input cmd, input field_select,
                input operand_a, input operand_b, output ready);
endinterface

// ----- rtl/core/gta_out_if.sv -----
// Result channel: one field element per beat.
interface gta_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] field_result;

  modport source (output valid, output field_result, input ready);
  modport sink (input valid, input field_result, output ready);
endinterface

// ----- rtl/core/gta_prep.sv -----
// First stage: mask operands to the selected field width and register.
module gta_prep (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               in_valid,
  input  logic               cmd,
  input  logic [1:0]         field_select,
  input  logic [7:0]         operand_a,
  input  logic [7:0]         operand_b,
  output logic               out_valid,
  output gta_pkg::prep_t     out_data
);

  gta_pkg::prep_t data_next;

  always_comb begin
    data_next.cmd  = cmd;
    data_next.mask = gta_pkg::field_mask(field_select);
    data_next.a    = operand_a & data_next.mask;
    data_next.b    = operand_b & data_next.mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= data_next;
    end
  end

endmodule

// ----- rtl/core/gta_mul16.sv -----
// Second stage: the three GF(16) Karatsuba sub-products and the field sum.
module gta_mul16 (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               in_valid,
  input  gta_pkg::prep_t     in_data,
  output logic               out_valid,
  output gta_pkg::part_t     out_data
);

  gta_pkg::part_t data_next;

  always_comb begin
    data_next.cmd  = in_data.cmd;
    data_next.mask = in_data.mask;
    data_next.sum  = in_data.a ^ in_data.b;
    data_next.lo   = gta_pkg::gf16_karatsuba(in_data.a[3:0], in_data.b[3:0]);
    data_next.hi   = gta_pkg::gf16_karatsuba(in_data.a[7:4], in_data.b[7:4]);
    data_next.mid  = gta_pkg::gf16_karatsuba(in_data.a[3:0] ^ in_data.a[7:4],
                                             in_data.b[3:0] ^ in_data.b[7:4])
                     ^ data_next.lo ^ data_next.hi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= data_next;
    end
  end

endmodule

// ----- rtl/core/gta_combine.sv -----
// Third stage: fold the sub-products, select sum or product and mask.
module gta_combine (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               in_valid,
  input  gta_pkg::part_t     in_data,
  output logic               out_valid,
  output logic [7:0]         out_result
);

  logic [7:0] product;
  logic [7:0] result_next;

  always_comb begin
    product = {in_data.mid ^ in_data.hi, in_data.lo ^ gta_pkg::gf16_by_8(in_data.hi)};
    case (in_data.cmd)
      gta_pkg::CMD_ADD: result_next = in_data.sum & in_data.mask;
      default:          result_next = product & in_data.mask;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result_next;
    end
  end

endmodule

// ----- rtl/core/gf256_tower_field_alu.sv -----
// Top level of the GF(256) tower-field ALU: add or multiply in GF(2/4/16/256).
// Takes one beat per cycle while ready and returns one result beat per operation,
// in order, through a three-stage pipeline (operand masking, GF(16) Karatsuba
// sub-products, final fold and select). Throughput is one operation per cycle;
// the pipeline moves as a whole and holds when the result register is full and
// not taken, so ready falls only under back-pressure.
module gf256_tower_field_alu (
  input  logic       clk,
  input  logic       rst,
  gta_in_if.sink     op,
  gta_out_if.source  res
);

  logic           advance;
  logic           s1_valid;
  logic           s2_valid;
  logic           s3_valid;
  gta_pkg::prep_t s1_data;
  gta_pkg::part_t s2_data;
  logic [7:0]     s3_result;

  assign advance  = !s3_valid || res.ready;
  assign op.ready = advance;

  gta_prep u_prep (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .in_valid     (op.valid),
    .cmd          (op.cmd),
    .field_select (op.field_select),
    .operand_a    (op.operand_a),
    .operand_b    (op.operand_b),
    .out_valid    (s1_valid),
    .out_data     (s1_data)
  );

  gta_mul16 u_mul16 (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (s1_valid),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_data  (s2_data)
  );

  gta_combine u_combine (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .in_valid   (s2_valid),
    .in_data    (s2_data),
    .out_valid  (s3_valid),
    .out_result (s3_result)
  );

  assign res.valid        = s3_valid;
  assign res.field_result = s3_result;

endmodule
